>>> hw/rtl/oom_pkg.sv
// ----------------------------------------------------------------------------
// Oligo overlap matrix package
// Shared constants, types and the overlap square table of the overlap matrix.
// ----------------------------------------------------------------------------
package oom_pkg;

   localparam int MAX_OLIGOS = 64;
   localparam int OLIGO_LEN  = 10;
   localparam int CHAR_W     = 8;
   localparam int OLIGO_W    = OLIGO_LEN * CHAR_W;
   localparam int IDX_W      = $clog2(MAX_OLIGOS);
   localparam int CNT_W      = $clog2(MAX_OLIGOS + 1);
   localparam int ROW_W      = 6;
   localparam int CMP_W      = ROW_W + 1;
   localparam int SHIFT_W    = 4;
   localparam int SQ_W       = 7;
   localparam int SUM_W      = 13;

   localparam logic [SHIFT_W-1:0] NO_OVERLAP = SHIFT_W'(OLIGO_LEN - 1);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_ROW  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ERROR,
      ST_FETCH_A,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      logic [OLIGO_W-1:0] wr_data;
      logic [IDX_W-1:0]   rd_addr;
   } store_req_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] shift;
      logic [SQ_W-1:0]    square;
   } overlap_type;

   function automatic logic [SQ_W-1:0] overlap_square(input logic [SHIFT_W-1:0] shift);
      logic [SQ_W-1:0] sq;
      case (shift)
         4'd0:    sq = 7'd81;
         4'd1:    sq = 7'd64;
         4'd2:    sq = 7'd49;
         4'd3:    sq = 7'd36;
         4'd4:    sq = 7'd25;
         4'd5:    sq = 7'd16;
         4'd6:    sq = 7'd9;
         4'd7:    sq = 7'd4;
         4'd8:    sq = 7'd1;
         default: sq = 7'd0;
      endcase
      return sq;
   endfunction

endpackage

>>> hw/rtl/oligo_overlap_matrix_unit.sv
// ----------------------------------------------------------------------------
// Oligo overlap matrix unit
// Stores oligos and streams one row of the suffix-prefix overlap matrix.
// ----------------------------------------------------------------------------
// A load transfer gives no result unless the store is full. A row transfer
// first fetches oligo A and then yields one result per stored oligo; the
// single read port of the store and the one overlap unit, which handles one
// column per cycle while the result side does not stall, set that pace. The
// store is not cleared after reset, and no new transfer is taken while a row
// is being produced.
module oligo_overlap_matrix_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic [oom_pkg::ROW_W-1:0]     req_row_index,
   input  logic [oom_pkg::CHAR_W-1:0]    req_char_0,
   input  logic [oom_pkg::CHAR_W-1:0]    req_char_1,
   input  logic [oom_pkg::CHAR_W-1:0]    req_char_2,
   input  logic [oom_pkg::CHAR_W-1:0]    req_char_3,
   input  logic [oom_pkg::CHAR_W-1:0]    req_char_4,
   input  logic [oom_pkg::CHAR_W-1:0]    req_char_5,
   input  logic [oom_pkg::CHAR_W-1:0]    req_char_6,
   input  logic [oom_pkg::CHAR_W-1:0]    req_char_7,
   input  logic [oom_pkg::CHAR_W-1:0]    req_char_8,
   input  logic [oom_pkg::CHAR_W-1:0]    req_char_9,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [oom_pkg::ROW_W-1:0]     rsp_column_index,
   output logic [oom_pkg::SHIFT_W-1:0]   rsp_shift,
   output logic [oom_pkg::SQ_W-1:0]      rsp_overlap_square,
   output logic [oom_pkg::SUM_W-1:0]     rsp_running_sum,
   output logic                          rsp_last_in_row,
   output logic                          rsp_error
);

   oom_pkg::state_type state_ff, state_in;
   logic [oom_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [oom_pkg::IDX_W-1:0]   col_ff, col_in;
   logic [oom_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [oom_pkg::OLIGO_W-1:0] a_ff, a_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [oom_pkg::ROW_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [oom_pkg::SHIFT_W-1:0] rsp_shift_ff, rsp_shift_in;
   logic [oom_pkg::SQ_W-1:0]    rsp_sq_ff, rsp_sq_in;
   logic [oom_pkg::SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_err_ff, rsp_err_in;

   oom_pkg::store_req_type      store_req;
   logic [oom_pkg::OLIGO_W-1:0] rd_data;
   oom_pkg::overlap_type        overlap;

   logic out_free;
   logic store_full;
   logic row_bad;
   logic col_last;
   logic [oom_pkg::SUM_W-1:0] sum_next;

   oom_store u_store (
      .clock      (clock),
      .store_req  (store_req),
      .rd_data_ff (rd_data)
   );

   oom_overlap_unit u_overlap (
      .oligo_a (a_ff),
      .oligo_b (rd_data),
      .result  (overlap)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign store_full = (count_ff == oom_pkg::CNT_W'(oom_pkg::MAX_OLIGOS));
   assign row_bad    = ({1'b0, req_row_index} >= oom_pkg::CMP_W'(count_ff));
   assign col_last   = ((oom_pkg::CNT_W'(col_ff) + 1'b1) == count_ff);
   assign sum_next   = sum_ff + oom_pkg::SUM_W'(overlap.square);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oom_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      sum_ff       <= sum_in;
      a_ff         <= a_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_shift_ff <= rsp_shift_in;
      rsp_sq_ff    <= rsp_sq_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      col_in    = col_ff;
      sum_in    = sum_ff;
      a_in      = a_ff;
      req_ready = 1'b0;

      store_req.wr_en   = 1'b0;
      store_req.wr_addr = count_ff[oom_pkg::IDX_W-1:0];
      store_req.wr_data = {req_char_9, req_char_8, req_char_7, req_char_6, req_char_5,
                           req_char_4, req_char_3, req_char_2, req_char_1, req_char_0};
      store_req.rd_addr = req_row_index[oom_pkg::IDX_W-1:0];

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_col_in   = rsp_col_ff;
      rsp_shift_in = rsp_shift_ff;
      rsp_sq_in    = rsp_sq_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         oom_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == oom_pkg::OP_LOAD) begin
                  if (store_full) begin
                     state_in = oom_pkg::ST_ERROR;
                  end else begin
                     store_req.wr_en = 1'b1;
                     count_in        = count_ff + 1'b1;
                  end
               end else if (row_bad) begin
                  state_in = oom_pkg::ST_ERROR;
               end else begin
                  state_in = oom_pkg::ST_FETCH_A;
               end
            end
         end
         oom_pkg::ST_ERROR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = '0;
               rsp_shift_in = '0;
               rsp_sq_in    = '0;
               rsp_sum_in   = '0;
               rsp_last_in  = 1'b0;
               rsp_err_in   = 1'b1;
               state_in     = oom_pkg::ST_IDLE;
            end
         end
         oom_pkg::ST_FETCH_A: begin
            a_in              = rd_data;
            sum_in            = '0;
            col_in            = '0;
            store_req.rd_addr = '0;
            state_in          = oom_pkg::ST_SCAN;
         end
         oom_pkg::ST_SCAN: begin
            store_req.rd_addr = col_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = oom_pkg::ROW_W'(col_ff);
               rsp_shift_in = overlap.shift;
               rsp_sq_in    = overlap.square;
               rsp_sum_in   = sum_next;
               rsp_last_in  = col_last;
               rsp_err_in   = 1'b0;
               sum_in       = sum_next;
               if (col_last) begin
                  state_in = oom_pkg::ST_IDLE;
               end else begin
                  col_in            = col_ff + 1'b1;
                  store_req.rd_addr = col_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = oom_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_column_index   = rsp_col_ff;
   assign rsp_shift          = rsp_shift_ff;
   assign rsp_overlap_square = rsp_sq_ff;
   assign rsp_running_sum    = rsp_sum_ff;
   assign rsp_last_in_row    = rsp_last_ff;
   assign rsp_error          = rsp_err_ff;

`ifndef ASSERT_OFF
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= oom_pkg::CNT_W'(oom_pkg::MAX_OLIGOS))
      else $error("Oligo count exceeds the store depth.");

   a_scan_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == oom_pkg::ST_SCAN) |-> (oom_pkg::CNT_W'(col_ff) < count_ff))
      else $error("Column index beyond the stored oligos during a row.");

   a_error_alone : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (!rsp_last_ff && rsp_sum_ff == '0))
      else $error("Error result carries row data.");
`endif

endmodule

>>> hw/rtl/oom_store.sv
// ----------------------------------------------------------------------------
// Oligo store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oom_store (
   input  logic                           clock,
   input  oom_pkg::store_req_type         store_req,
   output logic [oom_pkg::OLIGO_W-1:0]    rd_data_ff
);

   logic [oom_pkg::OLIGO_W-1:0] store_ff [oom_pkg::MAX_OLIGOS];

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         store_ff[store_req.wr_addr] <= store_req.wr_data;
      end
      rd_data_ff <= store_ff[store_req.rd_addr];
   end

endmodule

>>> hw/rtl/oom_overlap_unit.sv
// ----------------------------------------------------------------------------
// Overlap unit
// Finds the least shift at which the suffix of A equals the prefix of B and
// looks up the overlap square. Used once per column of a row.
// ----------------------------------------------------------------------------
module oom_overlap_unit (
   input  logic [oom_pkg::OLIGO_W-1:0] oligo_a,
   input  logic [oom_pkg::OLIGO_W-1:0] oligo_b,
   output oom_pkg::overlap_type        result
);

   localparam int NUM_SHIFTS = oom_pkg::OLIGO_LEN - 1;

   logic [NUM_SHIFTS-1:0] match;
   logic [oom_pkg::SHIFT_W-1:0] shift;

   for (genvar s = 0; s < NUM_SHIFTS; s++) begin : g_cmp
      localparam int W = oom_pkg::CHAR_W * (NUM_SHIFTS - s);
      assign match[s] = (oligo_a[oom_pkg::OLIGO_W-1 -: W] == oligo_b[W-1:0]);
   end

   always_comb begin
      shift = oom_pkg::NO_OVERLAP;
      for (int s = NUM_SHIFTS - 1; s >= 0; s--) begin
         if (match[s]) begin
            shift = oom_pkg::SHIFT_W'(s);
         end
      end
   end

   assign result.shift  = shift;
   assign result.square = oom_pkg::overlap_square(shift);

endmodule
